// File: src/div64_pkg.sv
// Shared types and constants for the 64-bit signed/unsigned divider.
package div64_pkg;

    localparam int PORT_W = 64;

    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIX
    } t_state;

    typedef struct packed {
        logic load;    // capture operands, take magnitudes
        logic step;    // one restoring shift-subtract iteration
        logic finish;  // sign fix-up into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free; // output register can take a new item this cycle
    } t_dp_sts;

endpackage

// File: src/div64_ctrl.sv
// Controller state machine of the divider: sequencing of load, iterations and fix-up.
module div64_ctrl
    import div64_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int CW = $clog2(DATA_WIDTH);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_count    = CW'(DATA_WIDTH - 1);
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
                if (r_count == '0) begin
                    n_state = ST_FIX;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            ST_FIX: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_count != '0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("iteration counter skipped");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("fix-up issued while output register busy");
    a_run_to_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_count == '0) |=> (r_state == ST_FIX))
        else $error("last iteration not followed by fix-up");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_RUN && r_count == CW'(DATA_WIDTH - 1)))
        else $error("load did not start iterations");
`endif

endmodule

// File: src/div64_dp.sv
// Datapath of the divider: magnitudes, restoring iteration, sign fix-up, output register.
module div64_dp
    import div64_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_opcode,
    input  logic [PORT_W-1:0] i_dividend,
    input  logic [PORT_W-1:0] i_divisor,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [PORT_W-1:0] o_quotient,
    output logic [PORT_W-1:0] o_remainder
);

    localparam int W = DATA_WIDTH;

    logic [W-1:0] r_num, r_den, r_rem;
    logic         r_q_flip, r_r_flip, r_dz;
    logic [W-1:0] r_q_out, r_r_out;
    logic         r_out_valid;

    // operand capture
    logic [W-1:0] n_in, d_in, n_mag, d_mag;
    logic         n_neg, d_neg, n_nz, d_nz;

    assign n_in  = i_dividend[W-1:0];
    assign d_in  = i_divisor[W-1:0];
    assign n_neg = (i_opcode == OP_SIGNED) && n_in[W-1];
    assign d_neg = (i_opcode == OP_SIGNED) && d_in[W-1];
    assign n_nz  = (n_in != '0);
    assign d_nz  = (d_in != '0);
    assign n_mag = n_neg ? (~n_in + 1'b1) : n_in;
    assign d_mag = d_neg ? (~d_in + 1'b1) : d_in;

    // one restoring step: carry bit of the shifted partial remainder kept in the compare
    logic [W:0]   rem_sh;
    logic [W-1:0] rem_sub;
    logic         q_bit;

    assign rem_sh  = {r_rem, r_num[W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh[W-1:0] - r_den;

    // sign fix-up
    logic [W-1:0] q_raw, r_raw, q_fix, r_fix;

    assign q_raw = r_dz ? '0 : r_num;
    assign r_raw = r_dz ? '1 : r_rem;
    assign q_fix = r_q_flip ? (~q_raw + 1'b1) : q_raw;
    assign r_fix = r_r_flip ? (~r_raw + 1'b1) : r_raw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num    <= n_mag;
            r_den    <= d_mag;
            r_rem    <= '0;
            r_dz     <= !d_nz;
            r_r_flip <= n_neg;
            r_q_flip <= (n_neg && d_nz && !d_neg) || (d_neg && n_nz && !n_neg);
        end else if (i_cmd.step) begin
            r_num <= {r_num[W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub : rem_sh[W-1:0];
        end
        if (i_cmd.finish) begin
            r_q_out <= q_fix;
            r_r_out <= r_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_valid        = r_out_valid;
    assign o_quotient     = PORT_W'(r_q_out);
    assign o_remainder    = PORT_W'(r_r_out);

endmodule

// File: src/divider_64bit_signed_unsigned_top.sv
// Top level of the signed/unsigned restoring divider: controller plus datapath.
// Operands are captured at the accept edge, then one quotient bit per cycle, then one fix-up
//   into the result register. A new item is taken only when idle, after the loop and fix-up
//   of the last item; a fix-up waits while the previous result is stalled.
// Reset (i_rst_n, synchronous, active low) idles the controller and empties the output.
module divider_64bit_signed_unsigned_top
    import div64_pkg::*;
#(
    parameter int DATA_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input item channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_opcode,
    input  logic [PORT_W-1:0] i_dividend,
    input  logic [PORT_W-1:0] i_divisor,
    // result item channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PORT_W-1:0] o_quotient,
    output logic [PORT_W-1:0] o_remainder
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencing: idle -> DATA_WIDTH iterations -> fix-up (waits for a free output slot)
    div64_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // operand magnitudes, restoring loop, sign correction, result register
    div64_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_opcode    (i_opcode),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

endmodule
